// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off while reset is low.
`define GPODC_ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("gpodc assertion failed");

// Same, on the usual clock and reset names.
`define GPODC_ASSERT(lbl, prop) \
    `GPODC_ASSERT_CLK(lbl, i_clk, i_rst_n, prop)

`endif

// ===== hw/rtl/gpodc_pkg.sv =====
package gpodc_pkg;

    localparam int PINS_PER_PORT = 16;
    localparam int FUNC_W        = 3;
    localparam int PORT_W        = 3;
    localparam int MODE_W        = 2;
    localparam int NUM_PORTS_DEF = 4;

    localparam logic [FUNC_W-1:0] OP_SETUP  = 3'd0;
    localparam logic [FUNC_W-1:0] OP_GET    = 3'd1;
    localparam logic [FUNC_W-1:0] OP_SET    = 3'd2;
    localparam logic [FUNC_W-1:0] OP_CLEAR  = 3'd3;
    localparam logic [FUNC_W-1:0] OP_TOGGLE = 3'd4;

    localparam logic [MODE_W-1:0] MODE_IN  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_OUT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OD  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_BAD = 2'd3;

    typedef logic [PINS_PER_PORT-1:0] t_pins;

    typedef struct packed {
        logic [FUNC_W-1:0]               func;
        logic [PORT_W-1:0]               port;
        t_pins                           pin_select;
        logic [MODE_W*PINS_PER_PORT-1:0] mode_bits;
        t_pins                           value_mask;
        t_pins                           pin_levels;
    } t_gpodc_req;

    typedef struct packed {
        t_pins read_data;
        t_pins direction_now;
        t_pins latch_now;
        logic  status;
    } t_gpodc_rsp;

    // One port's state, as stored in the port memory.
    typedef struct packed {
        t_pins od;
        t_pins latch;
        t_pins dir;
    } t_gpodc_entry;

endpackage

// ===== hw/rtl/gpio_port_open_drain_control_unit.sv =====
// Channel    Handshake              Payload   Direction
// request    start / busy           i_req     in
// result     o_done (one cycle)     o_rsp     out
//
// An item is read from the port memory in the cycle after it is taken and
// written back at the end of that cycle; the result is registered and follows in the next cycle.
// busy is high for one cycle after each accepted item, so no new item is
// taken while the read-modify-write of the port memory is under way.
// Reset clears the per-port valid bits; a port never written reads as zero.
// o_done is high for one cycle only, and results cannot be stalled.
module gpio_port_open_drain_control_unit #(
    parameter int NUM_PORTS = gpodc_pkg::NUM_PORTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  gpodc_pkg::t_gpodc_req i_req,
    output logic                  o_done,
    output gpodc_pkg::t_gpodc_rsp o_rsp
);
    import gpodc_pkg::*;

    localparam int AW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
    localparam int EW = $bits(t_gpodc_entry);
    localparam logic [PORT_W:0] PORT_LIMIT = (PORT_W + 1)'(NUM_PORTS);

    logic                 accept;
    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    t_gpodc_req           r_req;
    t_gpodc_rsp           r_rsp;
    logic [NUM_PORTS-1:0] r_valid, n_valid;
    logic [AW-1:0]        addr;
    logic                 port_ok;
    logic                 entry_valid;
    logic [EW-1:0]        ram_q;
    t_gpodc_entry         entry, new_entry;
    t_gpodc_rsp           rsp;
    logic                 we;

    assign accept  = start && !r_busy;
    assign addr    = r_req.port[AW-1:0];
    assign port_ok = {1'b0, r_req.port} < PORT_LIMIT;
    assign we      = r_busy && port_ok;

    always_comb begin
        entry_valid = 1'b0;
        for (int i = 0; i < NUM_PORTS; i++) begin
            if (addr == AW'(i)) begin
                entry_valid = r_valid[i];
            end
        end
    end

    // A port not yet written since reset reads as zero.
    assign entry = entry_valid ? t_gpodc_entry'(ram_q) : '0;

    gpodc_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_PORTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (addr),
        .i_wdata (EW'(new_entry)),
        .i_re    (accept),
        .i_raddr (i_req.port[AW-1:0]),
        .o_rdata (ram_q)
    );

    gpodc_alu u_alu (
        .i_req     (r_req),
        .i_entry   (entry),
        .i_port_ok (port_ok),
        .o_entry   (new_entry),
        .o_rsp     (rsp)
    );

    always_comb begin
        n_busy  = accept;
        n_done  = r_busy;
        n_valid = r_valid;
        for (int i = 0; i < NUM_PORTS; i++) begin
            if (we && (addr == AW'(i))) begin
                n_valid[i] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_valid <= '0;
        end else begin
            r_busy  <= n_busy;
            r_done  <= n_done;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
        end
        if (r_busy) begin
            r_rsp <= rsp;
        end
    end

    assign busy   = r_busy;
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

// ===== hw/rtl/gpodc_ram.sv =====
module gpodc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/gpodc_alu.sv =====
module gpodc_alu (
    input  gpodc_pkg::t_gpodc_req   i_req,
    input  gpodc_pkg::t_gpodc_entry i_entry,
    input  logic                    i_port_ok,
    output gpodc_pkg::t_gpodc_entry o_entry,
    output gpodc_pkg::t_gpodc_rsp   o_rsp
);
    import gpodc_pkg::*;

    t_pins sel, m, od, lat, dir;
    t_pins bad, first_bad, keep, app;
    t_pins in_m, out_m, od_m, odm;
    t_pins n_od, n_lat, n_dir, rd;
    logic  status;

    assign sel = i_req.pin_select;
    assign m   = i_req.value_mask & sel;
    assign od  = i_entry.od;
    assign lat = i_entry.latch;
    assign dir = i_entry.dir;
    assign odm = m & od;

    // Decode every pin's mode; in, out and open-drain apply only below the lowest bad pin.
    always_comb begin
        for (int i = 0; i < PINS_PER_PORT; i++) begin
            bad[i]   = sel[i] && (i_req.mode_bits[MODE_W*i +: MODE_W] == MODE_BAD);
            in_m[i]  = app[i] && (i_req.mode_bits[MODE_W*i +: MODE_W] == MODE_IN);
            out_m[i] = app[i] && (i_req.mode_bits[MODE_W*i +: MODE_W] == MODE_OUT);
            od_m[i]  = app[i] && (i_req.mode_bits[MODE_W*i +: MODE_W] == MODE_OD);
        end
    end

    // Walk stops at the lowest bad pin: keep only the pins below it.
    assign first_bad = bad & (~bad + t_pins'(1));
    assign keep      = (bad == '0) ? '1 : (first_bad - t_pins'(1));
    assign app       = sel & keep;

    always_comb begin
        n_od   = od;
        n_lat  = lat;
        n_dir  = dir;
        rd     = '0;
        status = 1'b0;
        case (i_req.func)
            OP_SETUP: begin
                n_od   = (od & ~(in_m | out_m)) | od_m;
                n_dir  = (dir & ~(in_m | od_m)) | out_m;
                n_lat  = lat & ~od_m;
                status = |bad;
            end
            OP_GET: begin
                rd = i_req.pin_levels & sel;
            end
            OP_SET: begin
                n_dir = dir & ~odm;
                n_lat = lat | (m & ~od);
            end
            OP_CLEAR: begin
                n_dir = dir | odm;
                n_lat = lat & ~(m & ~od);
            end
            OP_TOGGLE: begin
                n_dir = (dir & ~odm) | (odm & i_req.pin_levels);
                n_lat = lat ^ (m & ~od);
            end
            default: begin
                status = 1'b1;
            end
        endcase
    end

    assign o_entry = '{od: n_od, latch: n_lat, dir: n_dir};

    always_comb begin
        if (i_port_ok) begin
            o_rsp = '{read_data: rd, direction_now: n_dir, latch_now: n_lat,
                      status: status};
        end else begin
            o_rsp = '{read_data: '0, direction_now: '0, latch_now: '0,
                      status: 1'b1};
        end
    end

endmodule

// ===== hw/rtl/gpodc_checker.sv =====
`include "assert_macros.svh"

module gpodc_checker #(
    parameter int NUM_PORTS = gpodc_pkg::NUM_PORTS_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic                  busy,
    input gpodc_pkg::t_gpodc_req i_req,
    input logic                  o_done,
    input gpodc_pkg::t_gpodc_rsp o_rsp
);
    import gpodc_pkg::*;

    localparam logic [PORT_W:0] PORT_LIMIT = (PORT_W + 1)'(NUM_PORTS);

    logic  accept;
    logic  bad_port;
    logic  get_hit;
    t_pins get_data;
    logic  bad_rsp;

    assign accept   = start && !busy;
    assign bad_port = {1'b0, i_req.port} >= PORT_LIMIT;
    assign get_hit  = accept && !bad_port && (i_req.func == OP_GET);
    assign get_data = i_req.pin_levels & i_req.pin_select;
    assign bad_rsp  = o_rsp.status && (o_rsp.direction_now == '0)
                      && (o_rsp.latch_now == '0);

    `GPODC_ASSERT(a_accept_busy, accept |=> busy)
    `GPODC_ASSERT(a_accept_done, accept |-> ##2 o_done)
    `GPODC_ASSERT(a_done_idle, o_done |-> !busy)
    `GPODC_ASSERT(a_bad_port, (accept && bad_port) |-> ##2 bad_rsp)
    `GPODC_ASSERT(a_get_data, get_hit |-> ##2 (o_rsp.read_data == $past(get_data, 2)))

endmodule

bind gpio_port_open_drain_control_unit gpodc_checker #(
    .NUM_PORTS (NUM_PORTS)
) u_gpodc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_req   (i_req),
    .o_done  (o_done),
    .o_rsp   (o_rsp)
);
